/* hdl/assert_macros.svh */
// Assertion macros, included by csgim_div_cell.
// Each check is sampled on the rising edge of i_clk and is off while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate-style property on the current edge.
`define ASSERT_NOW(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Consequent checked on the following edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/csgim_pkg.sv */
// ----------------------------------------------------------------------------
// csgim_pkg
// Shared types, constants and helpers of the cube grid index map.
// ----------------------------------------------------------------------------
package csgim_pkg;

    localparam int MAX_DIM   = 256;
    localparam int DIM_W     = 9;
    localparam int CRD_W     = 8;
    localparam int IDX_W     = 24;
    localparam int DIV_W     = 10;
    localparam int PROD_W    = 18;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_X        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_Y        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_Z        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_FACES   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_INTERIOR = 3'd4;

    // Face codes.
    localparam logic [2:0] FACE_AUTO = 3'd0;
    localparam logic [2:0] FACE_X0   = 3'd1;
    localparam logic [2:0] FACE_X1   = 3'd2;
    localparam logic [2:0] FACE_Y0   = 3'd3;
    localparam logic [2:0] FACE_Y1   = 3'd4;
    localparam logic [2:0] FACE_Z0   = 3'd5;
    localparam logic [2:0] FACE_Z1   = 3'd6;

    // Point layouts.
    localparam logic [1:0] LAYOUT_SPLIT = 2'd0;
    localparam logic [1:0] LAYOUT_SURF  = 2'd1;
    localparam logic [1:0] LAYOUT_FULL  = 2'd2;

    // Sub-block selection for decoding.
    localparam logic [1:0] SEL_A = 2'd0;
    localparam logic [1:0] SEL_B = 2'd1;
    localparam logic [1:0] SEL_C = 2'd2;

    typedef struct packed {
        logic             mode;
        logic [CRD_W-1:0] coord_x;
        logic [CRD_W-1:0] coord_y;
        logic [CRD_W-1:0] coord_z;
        logic [2:0]       face;
        logic [IDX_W-1:0] point_index;
    } t_item;

    typedef struct packed {
        logic [DIM_W-1:0] grid_x;
        logic [DIM_W-1:0] grid_y;
        logic [DIM_W-1:0] grid_z;
        logic             split_faces;
        logic             keep_interior;
    } t_cfg;

    typedef struct packed {
        logic             mode;
        logic [1:0]       layout;
        logic [IDX_W-1:0] idx;
        logic [DIM_W-1:0] nx;
        logic [DIM_W-1:0] ny;
        logic [DIM_W-1:0] nz;
        logic [1:0]       sel;
        logic             hi;
        logic [IDX_W-1:0] q1;
        logic [DIV_W-1:0] r1;
    } t_ctx;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] num;
        logic [DIV_W-1:0] rem;
        logic [DIV_W-1:0] div;
        t_ctx             ctx;
    } t_div_stage;

    // Effective grid size: zero acts as one, large values saturate.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > DIM_W'(MAX_DIM)) begin
            r = DIM_W'(MAX_DIM);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

/* hdl/csgim_ifs.sv */
// ----------------------------------------------------------------------------
// csgim interfaces
// Valid/ready channels for items, results and configuration writes.
// ----------------------------------------------------------------------------
interface csgim_in_if import csgim_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             mode;
    logic [CRD_W-1:0] coord_x;
    logic [CRD_W-1:0] coord_y;
    logic [CRD_W-1:0] coord_z;
    logic [2:0]       face;
    logic [IDX_W-1:0] point_index;

    modport source (output valid, mode, coord_x, coord_y, coord_z, face, point_index,
                    input ready);
    modport sink   (input valid, mode, coord_x, coord_y, coord_z, face, point_index,
                    output ready);
endinterface

interface csgim_out_if import csgim_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] out_index;
    logic [CRD_W-1:0] out_x;
    logic [CRD_W-1:0] out_y;
    logic [CRD_W-1:0] out_z;

    modport source (output valid, out_index, out_x, out_y, out_z, input ready);
    modport sink   (input valid, out_index, out_x, out_y, out_z, output ready);
endinterface

interface csgim_cfg_if import csgim_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DIM_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/csgim_front.sv */
// ----------------------------------------------------------------------------
// csgim_front
// Four-stage front end: grid products, coordinate encoding and the
// sub-block selection that prepares the dividend for the divider chain.
// ----------------------------------------------------------------------------
module csgim_front import csgim_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic       i_valid,
    input  t_item      i_item,
    input  t_cfg       i_cfg,
    output t_div_stage o_stage
);

    // Stage 1: effective sizes and layout.
    logic             r1_valid;
    t_item            r1_item;
    logic [DIM_W-1:0] r1_nx, r1_ny, r1_nz;
    logic [1:0]       r1_layout;
    logic [DIM_W-1:0] n_nx, n_ny, n_nz;
    logic [1:0]       n_layout;

    always_comb begin
        n_nx = eff_dim(i_cfg.grid_x);
        n_ny = eff_dim(i_cfg.grid_y);
        n_nz = eff_dim(i_cfg.grid_z);
        if (i_cfg.split_faces) begin
            n_layout = LAYOUT_SPLIT;
        end else if (!i_cfg.keep_interior && n_nx > DIM_W'(1) && n_ny > DIM_W'(1)
                     && n_nz > DIM_W'(1)) begin
            n_layout = LAYOUT_SURF;
        end else begin
            n_layout = LAYOUT_FULL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid  <= i_valid;
            r1_item   <= i_item;
            r1_nx     <= n_nx;
            r1_ny     <= n_ny;
            r1_nz     <= n_nz;
            r1_layout <= n_layout;
        end
    end

    // Stage 2: face area products and single coordinate products.
    logic              r2_valid;
    t_item             r2_item;
    logic [DIM_W-1:0]  r2_nx, r2_ny, r2_nz;
    logic [1:0]        r2_layout;
    logic [PROD_W-1:0] r2_pxy, r2_pyz, r2_pxz, r2_mnyz, r2_mnxz, r2_mnxy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid  <= r1_valid;
            r2_item   <= r1_item;
            r2_nx     <= r1_nx;
            r2_ny     <= r1_ny;
            r2_nz     <= r1_nz;
            r2_layout <= r1_layout;
            r2_pxy    <= PROD_W'(r1_nx * r1_ny);
            r2_pyz    <= PROD_W'(r1_ny * r1_nz);
            r2_pxz    <= PROD_W'(r1_nx * r1_nz);
            r2_mnyz   <= PROD_W'(r1_ny * r1_item.coord_z);
            r2_mnxz   <= PROD_W'(r1_nx * r1_item.coord_z);
            r2_mnxy   <= PROD_W'(r1_nx * r1_item.coord_y);
        end
    end

    // Stage 3: second products, face resolution and decode selection.
    logic              r3_valid;
    t_item             r3_item;
    logic [DIM_W-1:0]  r3_nx, r3_ny, r3_nz;
    logic [1:0]        r3_layout;
    logic [PROD_W-1:0] r3_pxy, r3_pyz, r3_pxz, r3_mnxz, r3_mnxy, r3_mnyz;
    logic [IDX_W-1:0]  r3_full;
    logic [PROD_W-1:0] r3_ring_term;
    logic [2:0]        r3_face;
    logic [IDX_W-1:0]  r3_num;
    logic [DIV_W-1:0]  r3_div;
    logic [1:0]        r3_sel;
    logic              r3_hi;

    logic [DIV_W-1:0]  n_ring2;
    logic [CRD_W-1:0]  n_zm1;
    logic [2:0]        n_face;
    logic [IDX_W-1:0]  n_num, n_i1, n_i2, n_half, n_ii, n_pyz, n_pxz, n_pxy;
    logic [DIV_W-1:0]  n_div;
    logic [1:0]        n_sel;
    logic              n_hi;

    always_comb begin
        n_ring2 = DIV_W'({r2_nx, 1'b0}) + DIV_W'({r2_ny, 1'b0}) - DIV_W'(4);
        n_zm1   = r2_item.coord_z - CRD_W'(1);

        // Automatic face picks the first boundary face that matches.
        n_face = r2_item.face;
        if (r2_item.face == FACE_AUTO) begin
            if (r2_item.coord_x == '0) begin
                n_face = FACE_X0;
            end else if ({1'b0, r2_item.coord_x} == r2_nx - DIM_W'(1)) begin
                n_face = FACE_X1;
            end else if (r2_item.coord_y == '0) begin
                n_face = FACE_Y0;
            end else if ({1'b0, r2_item.coord_y} == r2_ny - DIM_W'(1)) begin
                n_face = FACE_Y1;
            end else if (r2_item.coord_z == '0) begin
                n_face = FACE_Z0;
            end else if ({1'b0, r2_item.coord_z} == r2_nz - DIM_W'(1)) begin
                n_face = FACE_Z1;
            end
        end

        // Select the sub-block and the dividend of the first division.
        n_ii   = r2_item.point_index;
        n_pyz  = IDX_W'(r2_pyz);
        n_pxz  = IDX_W'(r2_pxz);
        n_pxy  = IDX_W'(r2_pxy);
        n_half = n_pyz + n_pxz + n_pxy;
        n_hi   = 1'b0;
        n_i1   = n_ii;
        n_i2   = n_ii;
        n_num  = n_ii;
        n_div  = DIV_W'(r2_nx);
        n_sel  = SEL_A;
        unique case (r2_layout)
            LAYOUT_SPLIT: begin
                n_hi = (n_ii >= n_half);
                n_i1 = n_hi ? (n_ii - n_half) : n_ii;
                n_i2 = n_i1 - n_pyz;
                if (n_i1 < n_pyz) begin
                    n_sel = SEL_A;
                    n_num = n_i1;
                    n_div = DIV_W'(r2_ny);
                end else if (n_i2 < n_pxz) begin
                    n_sel = SEL_B;
                    n_num = n_i2;
                end else begin
                    n_sel = SEL_C;
                    n_num = n_i2 - n_pxz;
                end
            end
            LAYOUT_SURF: begin
                if (n_ii < n_pxy) begin
                    n_sel = SEL_A;
                end else if (n_ii < {n_pxy[IDX_W-2:0], 1'b0}) begin
                    n_sel = SEL_B;
                    n_num = n_ii - n_pxy;
                end else begin
                    n_sel = SEL_C;
                    n_num = n_ii - {n_pxy[IDX_W-2:0], 1'b0};
                    n_div = n_ring2;
                end
            end
            default: begin
                n_sel = SEL_A;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r3_valid     <= r2_valid;
            r3_item      <= r2_item;
            r3_nx        <= r2_nx;
            r3_ny        <= r2_ny;
            r3_nz        <= r2_nz;
            r3_layout    <= r2_layout;
            r3_pxy       <= r2_pxy;
            r3_pyz       <= r2_pyz;
            r3_pxz       <= r2_pxz;
            r3_mnxz      <= r2_mnxz;
            r3_mnxy      <= r2_mnxy;
            r3_mnyz      <= r2_mnyz;
            r3_full      <= IDX_W'(r2_nx * (r2_mnyz + PROD_W'(r2_item.coord_y)));
            r3_ring_term <= PROD_W'(n_ring2 * n_zm1);
            r3_face      <= n_face;
            r3_num       <= n_num;
            r3_div       <= n_div;
            r3_sel       <= n_sel;
            r3_hi        <= n_hi;
        end
    end

    // Stage 4: final encode sum and divider chain entry.
    logic [IDX_W-1:0] e_x, e_y, e_nx, e_ny, e_pxy, e_pyz, e_pxz;
    logic [IDX_W-1:0] e_mnxz, e_mnxy, e_mnyz, e_base, e_idx;
    t_div_stage       r4_stage;

    always_comb begin
        e_x    = IDX_W'(r3_item.coord_x);
        e_y    = IDX_W'(r3_item.coord_y);
        e_nx   = IDX_W'(r3_nx);
        e_ny   = IDX_W'(r3_ny);
        e_pxy  = IDX_W'(r3_pxy);
        e_pyz  = IDX_W'(r3_pyz);
        e_pxz  = IDX_W'(r3_pxz);
        e_mnxz = IDX_W'(r3_mnxz);
        e_mnxy = IDX_W'(r3_mnxy);
        e_mnyz = IDX_W'(r3_mnyz);
        e_base = {e_pxy[IDX_W-2:0], 1'b0} + IDX_W'(r3_ring_term);
        e_idx  = '0;
        unique case (r3_layout)
            LAYOUT_SPLIT: begin
                unique case (r3_face)
                    FACE_X0: e_idx = e_y + e_mnyz;
                    FACE_X1: e_idx = e_pyz + e_pxz + e_pxy + e_y + e_mnyz;
                    FACE_Y0: e_idx = e_pyz + e_x + e_mnxz;
                    FACE_Y1: e_idx = {e_pyz[IDX_W-2:0], 1'b0} + e_pxz + e_pxy + e_x + e_mnxz;
                    FACE_Z0: e_idx = e_pyz + e_pxz + e_x + e_mnxy;
                    FACE_Z1: e_idx = {e_pyz[IDX_W-2:0], 1'b0} + {e_pxz[IDX_W-2:0], 1'b0}
                                     + e_pxy + e_x + e_mnxy;
                    default: e_idx = '0;
                endcase
            end
            LAYOUT_SURF: begin
                priority if (r3_item.coord_z == '0) begin
                    e_idx = e_x + e_mnxy;
                end else if ({1'b0, r3_item.coord_z} == r3_nz - DIM_W'(1)) begin
                    e_idx = e_x + e_mnxy + e_pxy;
                end else if (r3_item.coord_y == '0) begin
                    e_idx = e_base + e_x;
                end else if ({1'b0, r3_item.coord_y} == r3_ny - DIM_W'(1)) begin
                    e_idx = e_base + e_x + e_nx;
                end else if (r3_item.coord_x == '0) begin
                    e_idx = e_base + {e_nx[IDX_W-2:0], 1'b0} + e_y - IDX_W'(1);
                end else begin
                    e_idx = e_base + {e_nx[IDX_W-2:0], 1'b0} + e_ny + e_y - IDX_W'(3);
                end
            end
            default: begin
                e_idx = e_x + r3_full;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_stage.valid <= 1'b0;
        end else if (i_en) begin
            r4_stage.valid      <= r3_valid;
            r4_stage.num        <= r3_num;
            r4_stage.rem        <= '0;
            r4_stage.div        <= r3_div;
            r4_stage.ctx.mode   <= r3_item.mode;
            r4_stage.ctx.layout <= r3_layout;
            r4_stage.ctx.idx    <= e_idx;
            r4_stage.ctx.nx     <= r3_nx;
            r4_stage.ctx.ny     <= r3_ny;
            r4_stage.ctx.nz     <= r3_nz;
            r4_stage.ctx.sel    <= r3_sel;
            r4_stage.ctx.hi     <= r3_hi;
            r4_stage.ctx.q1     <= '0;
            r4_stage.ctx.r1     <= '0;
        end
    end

    assign o_stage = r4_stage;

endmodule

/* hdl/csgim_div_cell.sv */
// ----------------------------------------------------------------------------
// csgim_div_cell
// One restoring division step: takes the top dividend bit into the
// remainder and shifts one quotient bit into the low end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module csgim_div_cell import csgim_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  t_div_stage i_stage,
    output t_div_stage o_stage
);

    logic [DIV_W:0]   n_trial;
    logic             n_ge;
    logic [DIV_W-1:0] n_rem;
    logic [DIV_W:0]   n_diff;
    t_div_stage       r_stage;

    // Compare the shifted remainder with the divisor.
    always_comb begin
        n_trial = {i_stage.rem, i_stage.num[IDX_W-1]};
        n_diff  = n_trial - {1'b0, i_stage.div};
        n_ge    = (n_trial >= {1'b0, i_stage.div});
        n_rem   = n_ge ? n_diff[DIV_W-1:0] : n_trial[DIV_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_en) begin
            r_stage.valid <= i_stage.valid;
            r_stage.num   <= {i_stage.num[IDX_W-2:0], n_ge};
            r_stage.rem   <= n_rem;
            r_stage.div   <= i_stage.div;
            r_stage.ctx   <= i_stage.ctx;
        end
    end

    assign o_stage = r_stage;

    `ASSERT_NOW(a_rem_below_div, !r_stage.valid || (r_stage.rem < r_stage.div), "remainder not below divisor")
    `ASSERT_NOW(a_div_nonzero, !r_stage.valid || (r_stage.div != '0), "zero divisor in chain")
    `ASSERT_NEXT(a_hold_on_stall, !i_en, $stable(r_stage.num) && $stable(r_stage.rem), "cell moved while stalled")

endmodule

/* hdl/csgim_div_chain.sv */
// ----------------------------------------------------------------------------
// csgim_div_chain
// Row of division cells, one per dividend bit; an item enters every cycle in which i_en is high.
// ----------------------------------------------------------------------------
module csgim_div_chain import csgim_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  t_div_stage i_head,
    output t_div_stage o_tail
);

    t_div_stage w_stage [0:IDX_W];

    assign w_stage[0] = i_head;

    // Each cell hands its partial quotient and remainder to the next.
    for (genvar k = 0; k < IDX_W; k++) begin : g_cell
        csgim_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_stage (w_stage[k]),
            .o_stage (w_stage[k+1])
        );
    end

    assign o_tail = w_stage[IDX_W];

endmodule

/* hdl/csgim_finish.sv */
// ----------------------------------------------------------------------------
// csgim_finish
// Builds the result fields from the encoded index or from the quotients
// and remainders and holds them in the output register.
// ----------------------------------------------------------------------------
module csgim_finish import csgim_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  t_div_stage       i_stage,
    output logic             o_valid,
    output logic [IDX_W-1:0] o_index,
    output logic [CRD_W-1:0] o_x,
    output logic [CRD_W-1:0] o_y,
    output logic [CRD_W-1:0] o_z
);

    t_ctx             c;
    logic [CRD_W-1:0] n_x, n_y, n_z, n_bx, n_by, n_bz;
    logic [CRD_W-1:0] n_q1, n_r1;
    logic [DIV_W:0]   n_ri, n_nx, n_2nx, n_edge;
    logic [IDX_W-1:0] n_index;

    logic             r_valid;
    logic [IDX_W-1:0] r_index;
    logic [CRD_W-1:0] r_x, r_y, r_z;

    always_comb begin
        c      = i_stage.ctx;
        n_q1   = c.q1[CRD_W-1:0];
        n_r1   = c.r1[CRD_W-1:0];
        n_bx   = c.hi ? CRD_W'(c.nx - DIM_W'(1)) : '0;
        n_by   = c.hi ? CRD_W'(c.ny - DIM_W'(1)) : '0;
        n_bz   = c.hi ? CRD_W'(c.nz - DIM_W'(1)) : '0;
        n_ri   = {1'b0, c.r1};
        n_nx   = (DIV_W+1)'(c.nx);
        n_2nx  = {n_nx[DIV_W-1:0], 1'b0};
        n_edge = n_2nx + (DIV_W+1)'(c.ny) - (DIV_W+1)'(2);
        n_x    = '0;
        n_y    = '0;
        n_z    = '0;
        n_index = '0;
        if (!c.mode) begin
            n_index = c.idx;
        end else begin
            unique case (c.layout)
                LAYOUT_SPLIT: begin
                    unique case (c.sel)
                        SEL_A: begin
                            n_x = n_bx; n_y = n_r1; n_z = n_q1;
                        end
                        SEL_B: begin
                            n_x = n_r1; n_y = n_by; n_z = n_q1;
                        end
                        default: begin
                            n_x = n_r1; n_y = n_q1; n_z = n_bz;
                        end
                    endcase
                end
                LAYOUT_SURF: begin
                    unique case (c.sel)
                        SEL_A: begin
                            n_x = n_r1; n_y = n_q1; n_z = '0;
                        end
                        SEL_B: begin
                            n_x = n_r1; n_y = n_q1; n_z = CRD_W'(c.nz - DIM_W'(1));
                        end
                        default: begin
                            // Side ring: front row, back row, left column, right column.
                            n_z = n_q1 + CRD_W'(1);
                            priority if (n_ri < n_nx) begin
                                n_x = n_r1;
                                n_y = '0;
                            end else if (n_ri < n_2nx) begin
                                n_x = CRD_W'(n_ri - n_nx);
                                n_y = CRD_W'(c.ny - DIM_W'(1));
                            end else if (n_ri < n_edge) begin
                                n_x = '0;
                                n_y = CRD_W'(n_ri - n_2nx + (DIV_W+1)'(1));
                            end else begin
                                n_x = CRD_W'(c.nx - DIM_W'(1));
                                n_y = CRD_W'(n_ri - n_edge + (DIV_W+1)'(1));
                            end
                        end
                    endcase
                end
                default: begin
                    n_x = n_r1;
                    n_y = i_stage.rem[CRD_W-1:0];
                    n_z = i_stage.num[CRD_W-1:0];
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_stage.valid;
            r_index <= n_index;
            r_x     <= n_x;
            r_y     <= n_y;
            r_z     <= n_z;
        end
    end

    assign o_valid = r_valid;
    assign o_index = r_index;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;

endmodule

/* hdl/cube_surface_grid_index_map.sv */
// ----------------------------------------------------------------------------
// cube_surface_grid_index_map
// Maps grid coordinates of a cube mesh to point numbers and back.
// ----------------------------------------------------------------------------
// Channels: i_in carries one lookup per transfer (mode, coordinates, face,
// point_index); o_out returns exactly one result per item, in order.
// i_cfg writes the five layout registers (grid sizes, split_faces,
// keep_interior) and is always ready; write it only while the block is idle.
// A result passes through four front stages, two chains of 24 division
// cells (one cell per dividend bit) and the output register.
// Throughput is one item per cycle unless o_out stalls; every stage moves
// at once. When the receiver stalls o_out, the whole pipeline holds and
// i_in.ready drops; it rises again as soon as the output register is taken.
// Reset (synchronous, active low) empties the pipeline and loads the
// registers with grid sizes 2, 2, 2 and both layout bits cleared.
// ----------------------------------------------------------------------------
module cube_surface_grid_index_map import csgim_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    csgim_cfg_if.sink  i_cfg,
    csgim_in_if.sink   i_in,
    csgim_out_if.source o_out
);

    t_cfg       r_cfg;
    t_item      w_item;
    logic       w_en;
    logic       w_out_valid;
    t_div_stage w_a_head, w_a_tail, w_b_head, w_b_tail;

    // Configuration register writes.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grid_x        <= DIM_W'(2);
            r_cfg.grid_y        <= DIM_W'(2);
            r_cfg.grid_z        <= DIM_W'(2);
            r_cfg.split_faces   <= 1'b0;
            r_cfg.keep_interior <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_GRID_X:        r_cfg.grid_x        <= i_cfg.data;
                CFG_GRID_Y:        r_cfg.grid_y        <= i_cfg.data;
                CFG_GRID_Z:        r_cfg.grid_z        <= i_cfg.data;
                CFG_SPLIT_FACES:   r_cfg.split_faces   <= i_cfg.data[0];
                CFG_KEEP_INTERIOR: r_cfg.keep_interior <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // Global advance: move whenever the output register is free or taken.
    assign w_en       = !w_out_valid || o_out.ready;
    assign i_in.ready = w_en;

    assign w_item.mode        = i_in.mode;
    assign w_item.coord_x     = i_in.coord_x;
    assign w_item.coord_y     = i_in.coord_y;
    assign w_item.coord_z     = i_in.coord_z;
    assign w_item.face        = i_in.face;
    assign w_item.point_index = i_in.point_index;

    csgim_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in.valid),
        .i_item  (w_item),
        .i_cfg   (r_cfg),
        .o_stage (w_a_head)
    );

    csgim_div_chain u_chain_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_head  (w_a_head),
        .o_tail  (w_a_tail)
    );

    // Second division: the first quotient over ny, used by the full grid.
    always_comb begin
        w_b_head        = w_a_tail;
        w_b_head.rem    = '0;
        w_b_head.div    = DIV_W'(w_a_tail.ctx.ny);
        w_b_head.ctx.q1 = w_a_tail.num;
        w_b_head.ctx.r1 = w_a_tail.rem;
    end

    csgim_div_chain u_chain_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_head  (w_b_head),
        .o_tail  (w_b_tail)
    );

    csgim_finish u_finish (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_stage (w_b_tail),
        .o_valid (w_out_valid),
        .o_index (o_out.out_index),
        .o_x     (o_out.out_x),
        .o_y     (o_out.out_y),
        .o_z     (o_out.out_z)
    );

    assign o_out.valid = w_out_valid;

endmodule

/* bench/cube_surface_grid_index_map_tb.sv */
// ----------------------------------------------------------------------------
// cube_surface_grid_index_map_tb
// Self-checking bench for the cube grid index map. Lookups are driven with
// random gaps, each accepted transfer is predicted by an in-bench mapper, and
// results are compared field by field in order. The layout registers are
// rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module cube_surface_grid_index_map_tb;
    import csgim_pkg::*;

    // Face code outside the six faces.
    localparam logic [2:0] FACE_BAD = 3'd7;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic [CRD_W-1:0] x;
        logic [CRD_W-1:0] y;
        logic [CRD_W-1:0] z;
    } t_point;

    // Scoreboard: predicts each accepted lookup and checks results in order.
    class point_scoreboard;
        t_point  pending[$];
        int      mismatches;
        int      checked;
        t_cfg    regs;

        function new();
            mismatches = 0;
            checked    = 0;
            regs       = '{grid_x: 9'd2, grid_y: 9'd2, grid_z: 9'd2,
                           split_faces: 1'b0, keep_interior: 1'b0};
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
            case (idx)
                CFG_GRID_X:        regs.grid_x = val;
                CFG_GRID_Y:        regs.grid_y = val;
                CFG_GRID_Z:        regs.grid_z = val;
                CFG_SPLIT_FACES:   regs.split_faces = val[0];
                CFG_KEEP_INTERIOR: regs.keep_interior = val[0];
                default: ;
            endcase
        endfunction

        function longint size_of(logic [DIM_W-1:0] v);
            if (v == 0) return 1;
            if (v > MAX_DIM) return MAX_DIM;
            return v;
        endfunction

        function longint map_coords(longint x, longint y, longint z, logic [2:0] f,
                                    longint nx, longint ny, longint nz);
            longint base;
            if (regs.split_faces) begin
                if (f == FACE_AUTO) begin
                    if (x == 0) f = FACE_X0;
                    else if (x == nx - 1) f = FACE_X1;
                    else if (y == 0) f = FACE_Y0;
                    else if (y == ny - 1) f = FACE_Y1;
                    else if (z == 0) f = FACE_Z0;
                    else if (z == nz - 1) f = FACE_Z1;
                end
                case (f)
                    FACE_X0: return y + ny * z;
                    FACE_X1: return ny*nz + nx*nz + nx*ny + y + ny*z;
                    FACE_Y0: return ny*nz + x + nx*z;
                    FACE_Y1: return 2*ny*nz + nx*nz + nx*ny + x + nx*z;
                    FACE_Z0: return ny*nz + nx*nz + x + nx*y;
                    FACE_Z1: return 2*ny*nz + 2*nx*nz + nx*ny + x + nx*y;
                    default: return 0;
                endcase
            end
            if (!regs.keep_interior && nx > 1 && ny > 1 && nz > 1) begin
                if (z == 0) return x + nx * y;
                if (z == nz - 1) return x + nx * (y + ny);
                base = 2*nx*ny + (2*nx + 2*ny - 4) * (z - 1);
                if (y == 0) return base + x;
                if (y == ny - 1) return base + x + nx;
                if (x == 0) return base + 2*nx + (y - 1);
                return base + 2*nx + (ny - 2) + (y - 1);
            end
            return x + nx * (y + ny * z);
        endfunction

        function t_point predict(t_item it);
            t_point p;
            longint nx, ny, nz, i, x, y, z, half, cap, ring;
            nx = size_of(regs.grid_x);
            ny = size_of(regs.grid_y);
            nz = size_of(regs.grid_z);
            p = '0;
            if (!it.mode) begin
                p.index = IDX_W'(map_coords(it.coord_x, it.coord_y, it.coord_z,
                                            it.face, nx, ny, nz));
                return p;
            end
            i = it.point_index;
            if (regs.split_faces) begin
                half = ny*nz + nx*nz + nx*ny;
                if (i < half) begin
                    x = 0; y = 0; z = 0;
                end else begin
                    i -= half; x = nx - 1; y = ny - 1; z = nz - 1;
                end
                if (i < ny*nz) begin
                    y = i % ny; z = i / ny;
                end else begin
                    i -= ny*nz;
                    if (i < nx*nz) begin
                        x = i % nx; z = i / nx;
                    end else begin
                        i -= nx*nz; x = i % nx; y = i / nx;
                    end
                end
            end else if (!regs.keep_interior && nx > 1 && ny > 1 && nz > 1) begin
                cap = nx * ny;
                if (i < cap) begin
                    x = i % nx; y = i / nx; z = 0;
                end else if (i < 2 * cap) begin
                    i -= cap; x = i % nx; y = i / nx; z = nz - 1;
                end else begin
                    ring = 2*nx + 2*(ny - 2);
                    i -= 2 * cap;
                    z = i / ring;
                    i -= z * ring;
                    z += 1;
                    if (i < nx) begin
                        x = i; y = 0;
                    end else if (i < 2*nx) begin
                        x = i - nx; y = ny - 1;
                    end else if (i < 2*nx + (ny - 2)) begin
                        x = 0; y = 1 + i - 2*nx;
                    end else begin
                        x = nx - 1; y = 1 + i - 2*nx - (ny - 2);
                    end
                end
            end else begin
                x = i % nx; i /= nx;
                y = i % ny; i /= ny;
                z = i;
            end
            p.x = CRD_W'(x);
            p.y = CRD_W'(y);
            p.z = CRD_W'(z);
            return p;
        endfunction

        function void note_lookup(t_item it);
            pending.insert(pending.size(), predict(it));
        endfunction

        function void check_result(t_point got);
            t_point want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result idx=%0d x=%0d y=%0d z=%0d",
                             got.index, got.x, got.y, got.z);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch idx/x/y/z: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                             want.index, want.x, want.y, want.z,
                             got.index, got.x, got.y, got.z);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    csgim_cfg_if cfg_ch();
    csgim_in_if  in_ch();
    csgim_out_if out_ch();

    cube_surface_grid_index_map u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch.sink),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    point_scoreboard board = new();
    bit   calm;        // no idling on either side while set
    int   configs_done;

    // Clock with a period of four units.
    always begin
        i_clk = 1'b1; #2;
        i_clk = 1'b0; #2;
    end

    // Receiver: stalls at random and checks each result transfer.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready)
                board.check_result('{index: out_ch.out_index, x: out_ch.out_x,
                                     y: out_ch.out_y, z: out_ch.out_z});
            out_ch.ready <= calm || ($urandom_range(99) >= 32);
        end
    end

    // Note every accepted lookup transfer.
    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready)
            board.note_lookup('{mode: in_ch.mode, coord_x: in_ch.coord_x,
                                coord_y: in_ch.coord_y, coord_z: in_ch.coord_z,
                                face: in_ch.face, point_index: in_ch.point_index});
    end

    // Send one lookup, with an optional random gap before it. Valid stays high
    // after the transfer so that back-to-back lookups leave no gap.
    task automatic send_lookup(t_item it);
        while (!calm && $urandom_range(99) < 32) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.mode        <= it.mode;
        in_ch.coord_x     <= it.coord_x;
        in_ch.coord_y     <= it.coord_y;
        in_ch.coord_z     <= it.coord_z;
        in_ch.face        <= it.face;
        in_ch.point_index <= it.point_index;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Wait until every predicted result has been checked, then let the pipe drain.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        board.set_reg(idx, val);
        configs_done++;
    endtask

    task automatic set_layout(int gx, int gy, int gz, bit sf, bit ki);
        drain();
        write_reg(CFG_GRID_X, DIM_W'(gx));
        write_reg(CFG_GRID_Y, DIM_W'(gy));
        write_reg(CFG_GRID_Z, DIM_W'(gz));
        write_reg(CFG_SPLIT_FACES, DIM_W'(sf));
        write_reg(CFG_KEEP_INTERIOR, DIM_W'(ki));
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic longint grid_n(logic [DIM_W-1:0] v);
        return board.size_of(v);
    endfunction

    // Random lookup, mostly near or on the grid, sometimes anywhere.
    function automatic t_item random_lookup();
        t_item  it;
        longint nx, ny, nz, total;
        nx = grid_n(board.regs.grid_x);
        ny = grid_n(board.regs.grid_y);
        nz = grid_n(board.regs.grid_z);
        total = board.regs.split_faces ? 2*(nx*ny + ny*nz + nx*nz) : nx*ny*nz;
        it.mode = 1'($urandom_range(1));
        it.face = 3'($urandom_range(7));
        if ($urandom_range(9) < 8) begin
            it.coord_x = CRD_W'($urandom_range(32'(nx - 1)));
            it.coord_y = CRD_W'($urandom_range(32'(ny - 1)));
            it.coord_z = CRD_W'($urandom_range(32'(nz - 1)));
            if ($urandom_range(1)) begin
                case ($urandom_range(2))
                    0: it.coord_x = $urandom_range(1) ? '0 : CRD_W'(nx - 1);
                    1: it.coord_y = $urandom_range(1) ? '0 : CRD_W'(ny - 1);
                    default: it.coord_z = $urandom_range(1) ? '0 : CRD_W'(nz - 1);
                endcase
            end
            it.point_index = IDX_W'($urandom_range(
                32'(total > 16777215 ? 16777215 : total - 1)));
        end else begin
            it.coord_x     = CRD_W'($urandom);
            it.coord_y     = CRD_W'($urandom);
            it.coord_z     = CRD_W'($urandom);
            it.point_index = IDX_W'($urandom);
        end
        return it;
    endfunction

    task automatic run_random(int count);
        repeat (count) send_lookup(random_lookup());
    endtask

    task automatic directed_set();
        t_item it;
        int f;
        // Each face code on a point with x = 0, an interior point and the extremes.
        for (f = 0; f < 8; f++) begin
            it = '{mode: 1'b0, coord_x: 8'd0, coord_y: 8'd1, coord_z: 8'd1,
                   face: 3'(f), point_index: '0};
            send_lookup(it);
        end
        it = '{mode: 1'b0, coord_x: 8'd1, coord_y: 8'd1, coord_z: 8'd1,
               face: FACE_AUTO, point_index: '0};
        send_lookup(it);
        it = '{mode: 1'b0, coord_x: 8'hFF, coord_y: 8'hFF, coord_z: 8'hFF,
               face: FACE_Z1, point_index: '1};
        send_lookup(it);
        it = '{mode: 1'b1, coord_x: 8'hFF, coord_y: 8'hFF, coord_z: 8'hFF,
               face: FACE_BAD, point_index: '1};
        send_lookup(it);
        it = '{mode: 1'b1, coord_x: 8'd0, coord_y: 8'd0, coord_z: 8'd0,
               face: FACE_AUTO, point_index: 24'd0};
        send_lookup(it);
        it.point_index = 24'd13;
        send_lookup(it);
    endtask

    // Main sequence: directed lookups, then random phases across layouts.
    initial begin
        i_rst_n           = 1'b0;
        calm              = 1'b0;
        configs_done      = 0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = '0;
        cfg_ch.data       = '0;
        in_ch.valid       = 1'b0;
        in_ch.mode        = 1'b0;
        in_ch.coord_x     = '0;
        in_ch.coord_y     = '0;
        in_ch.coord_z     = '0;
        in_ch.face        = '0;
        in_ch.point_index = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset layout first, then split faces on a 5x4x3 grid.
        directed_set();
        set_layout(5, 4, 3, 1'b1, 1'b0);
        directed_set();

        run_random(120);
        set_layout(7, 6, 5, 1'b0, 1'b0);
        run_random(100);
        // Sender holds off until every result is back.
        in_ch.valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        run_random(60);
        set_layout(3, 9, 4, 1'b0, 1'b1);
        run_random(100);
        // Zero acts as one and oversize values saturate.
        set_layout(0, 511, 1, 1'b0, 1'b0);
        run_random(80);
        set_layout(256, 256, 256, 1'b0, 1'b1);
        calm = 1'b1;
        run_random(100);
        calm = 1'b0;
        set_layout(256, 256, 256, 1'b1, 1'b0);
        run_random(80);
        set_layout(256, 256, 256, 1'b0, 1'b0);
        run_random(70);
        set_layout(1, 1, 1, 1'b1, 1'b1);
        run_random(50);
        set_layout(2, 3, 2, 1'b0, 1'b0);
        run_random(60);

        drain();
        $display("Covered split, surface and full-grid layouts, %0d results checked,",
                 board.checked);
        $display("%0d register writes including zero and oversize grid sizes.",
                 configs_done);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
